### sv/bva_pkg.sv
// Shared constants and types for the battery voltage averager.
package bva_pkg;

	localparam int WINDOW_LENGTH_DEF = 50;

	localparam int SAMPLE_W   = 12;
	localparam int RESULT_W   = 18;
	localparam int CAL_W      = 16;
	localparam int R2_W       = 17;
	localparam int SUMR_W     = 18;
	localparam int S_TDATA_W  = 16;
	localparam int M_TDATA_W  = 24;

	localparam logic [CAL_W-1:0]  CAL_RESET     = 16'd2500;
	localparam logic [CAL_W-1:0]  CAL_MIN       = 16'd2100;
	localparam logic [R2_W-1:0]   R2_OFFSET     = 17'd4000;
	localparam logic [SUMR_W-1:0] UPPER_OHMS    = 18'd10000;
	localparam logic [11:0]       FULL_SCALE_MV = 12'd3300;
	localparam int                ADC_MAX_CODE  = 4095;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_DIVGO,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

### sv/bva_div.sv
// Restoring divider, one quotient bit per cycle.
module bva_div import bva_pkg::*; #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 35,
	parameter int Q_W   = RESULT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output div_stat_t        stat,
	output logic [Q_W-1:0]   quot
);

	localparam int SH_W  = DEN_W + Q_W - 1;
	localparam int DIV_W = (SH_W > NUM_W) ? SH_W : NUM_W;
	localparam int CNT_W = $clog2(Q_W + 1);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsh_q;
	logic [Q_W-1:0]   quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(Q_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= DIV_W'(num);
			dsh_q  <= DIV_W'(den) << (Q_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[Q_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

### sv/battery_voltage_averager_core.sv
// Moving-average battery voltmeter: window sweep, shared multiplier, iterative divider.
//
// channel | direction | beat contents (low bit first)
// s_*     | in        | tdata: adc_sample[11:0], zero pad
// m_*     | out       | tdata: battery_millivolts[17:0], zero pad
// cfg_*   | in        | data: divider_calibration[15:0]
//
// m_tvalid rises once the sweep, the multiplier passes and the divider are through for an input beat;
// the next input beat is taken only after that result is loaded and the block is idle again.
// One window entry per cycle through the sample memory, three passes through the
// shared multiplier, then 18 divider steps. s_tready is high only when idle.
// Reset clears the window valid bits at once; no clearing pass is needed.
// A result waiting on m_tready holds the block in its final state.
module battery_voltage_averager_core import bva_pkg::*; #(
	parameter int WINDOW_LENGTH = WINDOW_LENGTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // adc_sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // battery_millivolts
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CAL_W-1:0]     cfg_data   // divider_calibration
);

	localparam int IDX_W = $clog2(WINDOW_LENGTH);
	localparam int SUM_W = SAMPLE_W + IDX_W;
	localparam int P1_W  = SUM_W + 12;
	localparam int NUM_W = P1_W + SUMR_W;
	localparam int DEN_W = R2_W + SUM_W;
	localparam int MA_W  = P1_W;
	localparam int MB_W  = (SUM_W > SUMR_W) ? SUM_W : SUMR_W;
	localparam int P_W   = MA_W + MB_W;
	localparam logic [SUM_W-1:0] NK = SUM_W'(WINDOW_LENGTH * ADC_MAX_CODE);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_LENGTH - 1);

	st_t state_q, state_d;

	logic [CAL_W-1:0]    cal_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    rd_addr_q;
	logic [SUM_W-1:0]    sum_q;
	logic [P_W-1:0]      prod_q;
	logic [NUM_W-1:0]    num_q;
	logic                m_tvalid_q;
	logic [RESULT_W-1:0] m_data_q;

	logic [SAMPLE_W-1:0] mem_q [WINDOW_LENGTH];
	logic [WINDOW_LENGTH-1:0] vld_q;
	logic [SAMPLE_W-1:0] rd_data_s1;
	logic                vld_s1;
	logic [IDX_W-1:0]    addr_s1;
	logic                act_s1;

	logic                keep;
	logic [SAMPLE_W-1:0] entry;
	logic                wr_en;
	logic [CAL_W-1:0]    cal_eff;
	logic [R2_W-1:0]     r2;
	logic [SUMR_W-1:0]   r_sum;
	logic [MA_W-1:0]     mul_a;
	logic [MB_W-1:0]     mul_b;
	logic                accept;
	logic                div_start;
	logic                load_out;
	div_stat_t           div_stat;
	logic [RESULT_W-1:0] div_quot;

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// calibration floor and lower resistor
	assign cal_eff = (cal_q < CAL_MIN) ? CAL_MIN : cal_q;
	assign r2      = {cal_eff, 1'b0} - R2_OFFSET;
	assign r_sum   = UPPER_OHMS + SUMR_W'(r2);

	// sweep write-back: oldest slot takes the new sample, empty or zero-valued slots fill
	assign keep  = vld_s1 && (rd_data_s1 != '0) && (addr_s1 != head_q);
	assign entry = keep ? rd_data_s1 : sample_q;
	assign wr_en = act_s1 && !keep;

	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_SWEEP;
			end
			ST_SWEEP: begin
				if (rd_addr_q == LAST_IDX) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				mul_a   = MA_W'(sum_q);
				mul_b   = MB_W'(FULL_SCALE_MV);
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				mul_a   = prod_q[MA_W-1:0];
				mul_b   = MB_W'(r_sum);
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				mul_a   = MA_W'(r2);
				mul_b   = MB_W'(NK);
				state_d = ST_DIVGO;
			end
			ST_DIVGO: begin
				div_start = 1'b1;
				state_d   = ST_OUT;
			end
			ST_OUT: begin
				if (div_stat.done || (!div_stat.busy && !div_start)) begin
					if (!m_tvalid_q || m_tready) begin
						load_out = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cal_q      <= CAL_RESET;
			head_q     <= '0;
			act_s1     <= 1'b0;
			vld_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) cal_q <= cfg_data;
			act_s1 <= (state_q == ST_SWEEP);
			if (wr_en) vld_q[addr_s1] <= 1'b1;
			if (state_q == ST_DRAIN) begin
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q  <= s_tdata[SAMPLE_W-1:0];
			sum_q     <= '0;
			rd_addr_q <= '0;
		end else begin
			if (state_q == ST_SWEEP && rd_addr_q != LAST_IDX) rd_addr_q <= rd_addr_q + 1'b1;
			if (act_s1) sum_q <= sum_q + SUM_W'(entry);
		end
		rd_data_s1 <= mem_q[rd_addr_q];
		vld_s1     <= vld_q[rd_addr_q];
		addr_s1    <= rd_addr_q;
		prod_q     <= P_W'(mul_a) * P_W'(mul_b);
		if (state_q == ST_MUL3) num_q <= prod_q[NUM_W-1:0];
		if (load_out) m_data_q <= div_quot;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[addr_s1] <= sample_q;
	end

	bva_div #(
		.NUM_W (NUM_W),
		.DEN_W (DEN_W),
		.Q_W   (RESULT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (prod_q[DEN_W-1:0]),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(m_data_q);

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LAST_IDX)
		else $error("window head out of range");

	a_div_done_out: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_OUT)
		else $error("divider finished outside result state");

	a_out_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside result state");

	a_busy_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> !s_tready)
		else $error("input ready while dividing");

endmodule
